[hdl/bev_pkg.sv]
// Shared types and constants for the button event qualifier.
// Holds the item, result and record structs and the register indexes.
// No dependencies.
`default_nettype none

package bev_pkg;

    localparam int REC_DEPTH = 32;
    localparam int REC_AW    = 5;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DC_WINDOW   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DC_COOLDOWN = CFG_IDX_W'(1);

    localparam logic [31:0] DC_WINDOW_RESET   = 32'd300000000;
    localparam logic [31:0] DC_COOLDOWN_RESET = 32'd500000000;

    localparam logic        FUNC_BUTTON = 1'b0;
    localparam logic        FUNC_AXIS   = 1'b1;

    localparam logic signed [15:0] AXIS_ONE = 16'sd32767;
    localparam logic [47:0]        HELD_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic               func;
        logic [3:0]         index;
        logic signed [15:0] sample_value;
        logic [63:0]        timestamp_ns;
        logic               frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] raw_out;
        logic               pressed;
        logic               released;
        logic signed [31:0] press_count;
        logic               toggle_state;
        logic               dbl_click;
        logic [47:0]        held_ns;
        logic [31:0]        cooldown_left_ns;
        logic [63:0]        last_click_ns;
        logic               bad_index;
    } t_out_item;

    // One record per button and per axis; D-pad axes use all fields but toggle.
    typedef struct packed {
        logic              prev_nz;
        logic signed [1:0] dpad_prev;
        logic [31:0]       count;
        logic              toggle;
        logic              dbl;
        logic [31:0]       cooldown;
        logic [47:0]       held;
        logic [63:0]       last_click;
    } t_rec;

    // Item as it travels from the read stage to the update stage.
    typedef struct packed {
        logic               func;
        logic               bad;
        logic               dpad;
        logic signed [15:0] value;
        logic [REC_AW-1:0]  addr;
        logic [63:0]        frame;
        logic [63:0]        dt;
    } t_stage;

endpackage

`default_nettype wire

[hdl/bev_rec_mem.sv]
// Record store: 32-entry synchronous memory with one write and one registered read port.
// Per-entry valid bits make unwritten entries read as an all-zero record.
// Depends on bev_pkg.
`default_nettype none

module bev_rec_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_rd_en,
    input  wire logic [bev_pkg::REC_AW-1:0] i_rd_addr,
    output bev_pkg::t_rec                  o_rd_data,
    input  wire logic                      i_wr_en,
    input  wire logic [bev_pkg::REC_AW-1:0] i_wr_addr,
    input  wire bev_pkg::t_rec             i_wr_data
);
    import bev_pkg::*;

    t_rec                 r_mem [REC_DEPTH];
    logic [REC_DEPTH-1:0] r_valid;
    t_rec                 r_rd_data;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

[hdl/bev_update.sv]
// Record update: computes the new record and the result for one sample.
// Covers buttons, D-pad axes and plain axes.
// Depends on bev_pkg.
`default_nettype none

module bev_update (
    input  wire bev_pkg::t_stage i_stage,
    input  wire bev_pkg::t_rec   i_rec,
    input  wire logic [31:0]     i_dc_window,
    input  wire logic [31:0]     i_dc_cooldown,
    output bev_pkg::t_rec        o_rec,
    output bev_pkg::t_out_item   o_res,
    output logic                 o_wr_en
);
    import bev_pkg::*;

    logic              nz;
    logic              press;
    logic              release_edge;
    logic signed [1:0] trunc;
    logic              held_same;
    logic [63:0]       since_click;
    logic              is_dbl;
    logic              cd_zero;
    logic [31:0]       cd_sub;
    logic [64:0]       held_sum;
    logic [47:0]       held_new;

    always_comb begin
        nz           = (i_stage.value != 16'sd0);
        press        = !i_rec.prev_nz && nz;
        release_edge = i_rec.prev_nz && !nz;

        if (i_stage.value >= AXIS_ONE) begin
            trunc = 2'sd1;
        end else if (i_stage.value <= -AXIS_ONE) begin
            trunc = -2'sd1;
        end else begin
            trunc = 2'sd0;
        end

        since_click = i_stage.frame - i_rec.last_click;
        is_dbl      = since_click < {32'd0, i_dc_window};
        cd_zero     = (i_rec.cooldown == 32'd0);
        cd_sub      = (i_stage.dt >= {32'd0, i_rec.cooldown}) ? 32'd0 :
                      (i_rec.cooldown - i_stage.dt[31:0]);

        if (i_stage.dpad) begin
            held_same = (i_rec.dpad_prev == trunc) && (trunc != 2'sd0);
        end else begin
            held_same = i_rec.prev_nz && nz;
        end
        // Saturate when held + dt reaches the ceiling.
        held_sum = {17'd0, i_rec.held} + {1'b0, i_stage.dt};
        if (!held_same) begin
            held_new = '0;
        end else if (held_sum[64:48] != 17'd0 || held_sum[47:0] == HELD_MAX) begin
            held_new = HELD_MAX;
        end else begin
            held_new = held_sum[47:0];
        end

        o_rec         = i_rec;
        o_rec.prev_nz = nz;
        o_res         = '0;
        o_wr_en       = !i_stage.bad;

        if (i_stage.bad) begin
            o_res.bad_index = 1'b1;
        end else if (i_stage.func == FUNC_BUTTON) begin
            if (press) begin
                if (cd_zero) begin
                    o_rec.dbl = is_dbl;
                end else begin
                    o_rec.cooldown = cd_sub;
                end
                o_rec.count      = i_rec.count + 32'd1;
                o_rec.toggle     = !i_rec.toggle;
                o_rec.last_click = i_stage.frame;
            end
            if (release_edge) begin
                if (i_rec.dbl) begin
                    o_rec.cooldown = i_dc_cooldown;
                end
                o_rec.dbl = 1'b0;
            end
            o_rec.held = held_new;

            o_res.raw_out          = i_stage.value;
            o_res.pressed          = press;
            o_res.released         = release_edge;
            o_res.press_count      = o_rec.count;
            o_res.toggle_state     = o_rec.toggle;
            o_res.dbl_click        = o_rec.dbl;
            o_res.held_ns          = o_rec.held;
            o_res.cooldown_left_ns = o_rec.cooldown;
            o_res.last_click_ns    = o_rec.last_click;
        end else if (i_stage.dpad) begin
            if (press) begin
                if (cd_zero) begin
                    o_rec.dbl = is_dbl;
                end
                o_rec.count      = i_rec.count + {{30{trunc[1]}}, trunc};
                o_rec.last_click = i_stage.frame;
            end
            // The D-pad cooldown runs down on every sample.
            o_rec.cooldown = cd_sub;
            if (release_edge) begin
                if (o_rec.dbl) begin
                    o_rec.cooldown = i_dc_cooldown;
                end
                o_rec.dbl = 1'b0;
            end
            o_rec.held      = held_new;
            o_rec.dpad_prev = trunc;

            o_res.raw_out          = {{14{trunc[1]}}, trunc};
            o_res.pressed          = press;
            o_res.released         = release_edge;
            o_res.press_count      = o_rec.count;
            o_res.dbl_click        = o_rec.dbl;
            o_res.held_ns          = o_rec.held;
            o_res.cooldown_left_ns = o_rec.cooldown;
            o_res.last_click_ns    = o_rec.last_click;
        end else begin
            o_res.raw_out  = i_stage.value;
            o_res.pressed  = press;
            o_res.released = release_edge;
        end
    end

endmodule

`default_nettype wire

[hdl/button_event_qualifier.sv]
// Button event qualifier: edges, counts, toggle, double click and hold time per input.
// An item is registered in the update stage, then its result in the output register. Throughput: one
// item per cycle unless the output stalls; the record store is read at acceptance and written back as
// the item leaves the update stage, with forwarding when consecutive items hit the same record.
// Reset: all records read as zero through per-entry valid bits, registers take defaults.
// Depends on bev_pkg, bev_rec_mem and bev_update.
`default_nettype none

module button_event_qualifier #(
    parameter int MAX_BUTTONS = 16,
    parameter int MAX_AXES    = 8,
    parameter int DPAD_BASE   = 6
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire bev_pkg::t_in_item            i_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output bev_pkg::t_out_item                o_out,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [bev_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                  i_cfg_data
);
    import bev_pkg::*;

    logic [31:0] r_dc_window;
    logic [31:0] r_dc_cooldown;
    logic [63:0] r_frame;
    logic [63:0] r_prev_frame;
    logic [63:0] n_frame;
    logic [63:0] n_prev_frame;

    logic        r_b_valid;
    t_stage      r_b;
    t_stage      n_b;
    logic        r_b_fwd;
    t_rec        r_fwd_rec;

    logic        r_out_valid;
    t_out_item   r_out;

    logic        accept;
    logic        b_adv;
    logic        wr_en;
    logic        upd_wr;
    t_rec        rd_rec;
    t_rec        cur_rec;
    t_rec        new_rec;
    t_out_item   result;

    assign b_adv       = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_b_valid || b_adv;
    assign accept      = i_in_valid && o_in_ready;
    assign wr_en       = r_b_valid && b_adv && upd_wr;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_frame      = i_in.frame_start ? i_in.timestamp_ns : r_frame;
        n_prev_frame = i_in.frame_start ? r_frame : r_prev_frame;

        n_b       = '0;
        n_b.func  = i_in.func;
        n_b.value = i_in.sample_value;
        n_b.addr  = {i_in.func, i_in.index};
        n_b.frame = n_frame;
        n_b.dt    = n_frame - n_prev_frame;
        if (i_in.func == FUNC_BUTTON) begin
            n_b.bad = (32'(i_in.index) >= MAX_BUTTONS);
        end else begin
            n_b.bad  = (32'(i_in.index) >= MAX_AXES);
            n_b.dpad = (32'(i_in.index) == DPAD_BASE) ||
                       (32'(i_in.index) == DPAD_BASE + 1);
        end
    end

    bev_rec_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (n_b.addr),
        .o_rd_data (rd_rec),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_b.addr),
        .i_wr_data (new_rec)
    );

    assign cur_rec = r_b_fwd ? r_fwd_rec : rd_rec;

    bev_update u_update (
        .i_stage       (r_b),
        .i_rec         (cur_rec),
        .i_dc_window   (r_dc_window),
        .i_dc_cooldown (r_dc_cooldown),
        .o_rec         (new_rec),
        .o_res         (result),
        .o_wr_en       (upd_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_window   <= DC_WINDOW_RESET;
            r_dc_cooldown <= DC_COOLDOWN_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_DC_WINDOW) begin
                r_dc_window <= i_cfg_data;
            end else if (i_cfg_index == CFG_DC_COOLDOWN) begin
                r_dc_cooldown <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame      <= '0;
            r_prev_frame <= '0;
            r_b_valid    <= 1'b0;
            r_b_fwd      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_frame      <= n_frame;
                r_prev_frame <= n_prev_frame;
                r_b_valid    <= 1'b1;
                // The memory read misses a write-back to the same entry in this cycle.
                r_b_fwd      <= wr_en && (r_b.addr == n_b.addr);
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (r_b_valid && b_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b       <= n_b;
            r_fwd_rec <= new_rec;
        end
        if (r_b_valid && b_adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for button_event_qualifier: a directed table of samples, then random phases.
// Each result is compared against its typed row or a behavioral predictor of the qualifier kept here.
// Depends on bev_pkg and the button_event_qualifier RTL.

module tb_top;
    import bev_pkg::*;

    localparam int N_BUTTONS   = 16;
    localparam int N_AXES      = 8;
    localparam int PAD_FIRST   = 6;
    localparam int RAND_ITEMS  = 200;
    localparam int N_PHASES    = 4;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 200000;

    localparam t_out_item NO_RESULT  = '0;
    localparam t_out_item BAD_RESULT = '{bad_index: 1'b1, default: '0};
    localparam t_out_item FIRST_PRESS = '{raw_out: 16'sd1, pressed: 1'b1, press_count: 32'sd1,
                                          toggle_state: 1'b1, dbl_click: 1'b1,
                                          last_click_ns: 64'd1000, default: '0};

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item exp_res;
    } t_row;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_item             in_item = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DC_WINDOW;
    logic [31:0]          cfg_data = '0;

    // Expectation that travels with the current sample when its result is typed in the table.
    bit        in_typed = 1'b0;
    t_out_item in_exp = '0;

    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int          cycles = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    t_out_item   results_due[$];
    t_out_item   predicted;
    t_out_item   arrived;
    t_row        plan[$];
    logic [63:0] stamp_cursor = '0;

    // Predictor state: configuration, frame latch and per-index records.
    logic [31:0]       win_ns = DC_WINDOW_RESET;
    logic [31:0]       cool_ns = DC_COOLDOWN_RESET;
    logic [63:0]       frame_now = '0;
    logic [63:0]       frame_before = '0;
    logic              btn_down    [N_BUTTONS] = '{default: '0};
    logic [31:0]       btn_presses [N_BUTTONS] = '{default: '0};
    logic              btn_tog     [N_BUTTONS] = '{default: '0};
    logic              btn_dbl     [N_BUTTONS] = '{default: '0};
    logic [31:0]       btn_lock    [N_BUTTONS] = '{default: '0};
    logic [47:0]       btn_hold    [N_BUTTONS] = '{default: '0};
    logic [63:0]       btn_click   [N_BUTTONS] = '{default: '0};
    logic              ax_nz       [N_AXES] = '{default: '0};
    logic signed [1:0] pad_dir     [2] = '{default: '0};
    logic [31:0]       pad_presses [2] = '{default: '0};
    logic              pad_dbl     [2] = '{default: '0};
    logic [31:0]       pad_lock    [2] = '{default: '0};
    logic [47:0]       pad_hold    [2] = '{default: '0};
    logic [63:0]       pad_click   [2] = '{default: '0};

    button_event_qualifier u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] lock_after(logic [31:0] c, logic [63:0] d);
        return (d >= {32'd0, c}) ? 32'd0 : c - d[31:0];
    endfunction

    function automatic logic [47:0] hold_after(logic [47:0] h, logic same, logic [63:0] d);
        if (!same) begin
            return '0;
        end
        if (h == HELD_MAX || d >= {16'd0, HELD_MAX - h}) begin
            return HELD_MAX;
        end
        return h + d[47:0];
    endfunction

    function automatic logic within_window(logic [63:0] last);
        return (frame_now - last) < {32'd0, win_ns};
    endfunction

    // Advances the predictor by one sample and returns the result it should produce.
    function automatic t_out_item qualify_sample(t_in_item it);
        t_out_item         r;
        logic              nz;
        logic              was;
        logic              press;
        logic              rel;
        logic [63:0]       dt;
        logic signed [1:0] dir;
        int                i;
        int                j;
        r = '0;
        if (it.frame_start) begin
            frame_before = frame_now;
            frame_now = it.timestamp_ns;
        end
        dt = frame_now - frame_before;
        i = it.index;
        nz = (it.sample_value != 0);
        if ((it.func == FUNC_BUTTON && i >= N_BUTTONS) || (it.func == FUNC_AXIS && i >= N_AXES)) begin
            r.bad_index = 1'b1;
            return r;
        end
        if (it.func == FUNC_BUTTON) begin
            was = btn_down[i];
            press = !was && nz;
            rel = was && !nz;
            if (press) begin
                // A pending lockout is only worn down by presses, never re-qualifies.
                if (btn_lock[i] == 0) begin
                    btn_dbl[i] = within_window(btn_click[i]);
                end else begin
                    btn_lock[i] = lock_after(btn_lock[i], dt);
                end
                btn_presses[i] = btn_presses[i] + 32'd1;
                btn_tog[i] = !btn_tog[i];
                btn_click[i] = frame_now;
            end
            if (rel) begin
                if (btn_dbl[i]) begin
                    btn_lock[i] = cool_ns;
                end
                btn_dbl[i] = 1'b0;
            end
            btn_hold[i] = hold_after(btn_hold[i], was && nz, dt);
            btn_down[i] = nz;
            r.raw_out = it.sample_value;
            r.pressed = press;
            r.released = rel;
            r.press_count = btn_presses[i];
            r.toggle_state = btn_tog[i];
            r.dbl_click = btn_dbl[i];
            r.held_ns = btn_hold[i];
            r.cooldown_left_ns = btn_lock[i];
            r.last_click_ns = btn_click[i];
            return r;
        end
        was = ax_nz[i];
        press = !was && nz;
        rel = was && !nz;
        ax_nz[i] = nz;
        r.pressed = press;
        r.released = rel;
        if (i == PAD_FIRST || i == PAD_FIRST + 1) begin
            j = i - PAD_FIRST;
            dir = (it.sample_value >= AXIS_ONE) ? 2'sb01 :
                  (it.sample_value <= -AXIS_ONE) ? 2'sb11 : 2'sb00;
            if (press) begin
                if (pad_lock[j] == 0) begin
                    pad_dbl[j] = within_window(pad_click[j]);
                end
                pad_presses[j] = pad_presses[j] + {{30{dir[1]}}, dir};
                pad_click[j] = frame_now;
            end
            pad_lock[j] = lock_after(pad_lock[j], dt);
            if (rel) begin
                if (pad_dbl[j]) begin
                    pad_lock[j] = cool_ns;
                end
                pad_dbl[j] = 1'b0;
            end
            pad_hold[j] = hold_after(pad_hold[j], pad_dir[j] == dir && dir != 0, dt);
            pad_dir[j] = dir;
            r.raw_out = {{14{dir[1]}}, dir};
            r.press_count = pad_presses[j];
            r.dbl_click = pad_dbl[j];
            r.held_ns = pad_hold[j];
            r.cooldown_left_ns = pad_lock[j];
            r.last_click_ns = pad_click[j];
        end else begin
            r.raw_out = it.sample_value;
        end
        return r;
    endfunction

    function automatic t_in_item pack_sample(logic f, int idx, int v, logic [63:0] st, logic fs);
        t_in_item it;
        it.func = f;
        it.index = idx[3:0];
        it.sample_value = v[15:0];
        it.timestamp_ns = st;
        it.frame_start = fs;
        return it;
    endfunction

    // Mostly press, hold and release runs on a few records, with noise and bad indexes mixed in.
    function automatic t_in_item random_sample();
        t_in_item it;
        int       roll;
        it = '0;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            it.func = FUNC_BUTTON;
            it.index = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(0, 2));
            roll = $urandom_range(0, 99);
            it.sample_value = (roll < 45) ? 16'sd0 : (roll < 85) ? 16'sd1 : 16'($urandom);
        end else begin
            it.func = FUNC_AXIS;
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                it.index = 4'($urandom_range(N_AXES, 15));
            end else if (roll < 40) begin
                it.index = 4'($urandom_range(0, PAD_FIRST - 1));
            end else begin
                it.index = 4'(PAD_FIRST + $urandom_range(0, 1));
            end
            case ($urandom_range(0, 5))
                0, 1: begin
                    it.sample_value = 16'sd0;
                end
                2: begin
                    it.sample_value = AXIS_ONE;
                end
                3: begin
                    it.sample_value = -AXIS_ONE;
                end
                4: begin
                    it.sample_value = 16'sh8000;
                end
                default: begin
                    it.sample_value = 16'($urandom);
                end
            endcase
        end
        it.frame_start = ($urandom_range(0, 9) < 4);
        if (!it.frame_start || $urandom_range(0, 19) == 0) begin
            it.timestamp_ns = {$urandom, $urandom};
        end else begin
            it.timestamp_ns = stamp_cursor + 64'($urandom_range(0, 600));
        end
        if (it.frame_start) begin
            stamp_cursor = it.timestamp_ns;
        end
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic compare_result(t_out_item got, t_out_item want);
        check_field("raw_out", got.raw_out, want.raw_out);
        check_field("pressed", got.pressed, want.pressed);
        check_field("released", got.released, want.released);
        check_field("press_count", got.press_count, want.press_count);
        check_field("toggle_state", got.toggle_state, want.toggle_state);
        check_field("dbl_click", got.dbl_click, want.dbl_click);
        check_field("held_ns", got.held_ns, want.held_ns);
        check_field("cooldown_left_ns", got.cooldown_left_ns, want.cooldown_left_ns);
        check_field("last_click_ns", got.last_click_ns, want.last_click_ns);
        check_field("bad_index", got.bad_index, want.bad_index);
    endtask

    task automatic offer_item(input t_in_item it, input bit typed, input t_out_item ex);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item = it;
        in_typed = typed;
        in_exp = ex;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_index = idx;
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (results_due.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Config, input and result channels are observed here, in that order, so prediction order is fixed.
    always @(posedge clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DC_WINDOW: begin
                        win_ns = cfg_data;
                    end
                    CFG_DC_COOLDOWN: begin
                        cool_ns = cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (in_valid && in_ready) begin
                predicted = qualify_sample(in_item);
                results_due.push_back(in_typed ? in_exp : predicted);
            end
            if (out_valid && out_ready) begin
                results_seen++;
                arrived = out_item;
                if (results_due.size() == 0) begin
                    report_mismatch("result arrived with nothing outstanding");
                end else begin
                    compare_result(arrived, results_due.pop_front());
                end
            end
        end
    end

    // Result side: random stalls, plus one long hold-off that lets the block back up.
    initial begin
        int gap;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            gap = quiet ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin
        logic [31:0] w;
        logic [31:0] c;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Typed rows: first press after reset and the bad axis indexes.
        plan.push_back('{pack_sample(FUNC_BUTTON, 0, 1, 64'd1000, 1'b1), 1'b1, FIRST_PRESS});
        plan.push_back('{pack_sample(FUNC_AXIS, 8, 5, 64'd0, 1'b0), 1'b1, BAD_RESULT});
        plan.push_back('{pack_sample(FUNC_AXIS, 15, -32768, '1, 1'b1), 1'b1, BAD_RESULT});
        // Huge frame step saturates the hold time, then release after a double click.
        plan.push_back('{pack_sample(FUNC_BUTTON, 0, 1, 64'd0, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_BUTTON, 0, 0, 64'd0, 1'b0), 1'b0, NO_RESULT});
        // Timestamp wraps to zero; a press with a lockout pending wears it down.
        plan.push_back('{pack_sample(FUNC_BUTTON, 0, -32768, 64'd0, 1'b1), 1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_BUTTON, 15, 32767, 64'd0, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_BUTTON, 15, 0, 64'd0, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_AXIS, 0, -32767, 64'd0, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_AXIS, 0, 0, 64'd0, 1'b0), 1'b0, NO_RESULT});
        // D-pad press whose value truncates to zero still counts as a press.
        plan.push_back('{pack_sample(FUNC_AXIS, 7, 100, 64'd0, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_AXIS, 7, 0, 64'd0, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_AXIS, 6, 32767, 64'd100, 1'b1), 1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_AXIS, 6, 32767, 64'd200, 1'b1), 1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_AXIS, 6, 0, 64'd0, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_AXIS, 6, -32768, 64'd5000, 1'b1), 1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_AXIS, 7, -32767, 64'd0, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_AXIS, 7, -1, 64'd0, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_BUTTON, 3, 1, 64'h8000_0000_0000_0000, 1'b1),
                         1'b0, NO_RESULT});
        plan.push_back('{pack_sample(FUNC_AXIS, 5, 32767, 64'd0, 1'b0), 1'b0, NO_RESULT});

        foreach (plan[k]) begin
            offer_item(plan[k].item, plan[k].typed, plan[k].exp_res);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    w = '0;
                    c = '0;
                end
                1: begin
                    w = '1;
                    c = '1;
                end
                2: begin
                    w = 32'd1000;
                    c = 32'd3000;
                end
                default: begin
                    w = $urandom_range(100, 5000);
                    c = $urandom;
                end
            endcase
            write_reg(CFG_DC_WINDOW, w);
            write_reg(CFG_DC_COOLDOWN, c);
            quiet = (ph == 1);
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            repeat (RAND_ITEMS) offer_item(random_sample(), 1'b0, NO_RESULT);
        end

        settle();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/bev_pkg.sv
hdl/bev_rec_mem.sv
hdl/bev_update.sv
hdl/button_event_qualifier.sv
tb/tb_top.sv
